// ----- hw/rtl/ghash_pkg.sv -----
// ----------------------------------------------------------------------------
// ghash_pkg
// Shared types and constants for the GHASH tag engine: block geometry, the
// GF(2^128) reduction polynomial, digit sizes, register indexes and states.
// ----------------------------------------------------------------------------
package ghash_pkg;

   // Block geometry
   localparam int unsigned BlockW      = 128;
   localparam int unsigned HalfW       = 64;
   localparam int unsigned ByteW       = 8;
   localparam int unsigned BlockBytes  = BlockW / ByteW;
   localparam logic [4:0]  BlockBytesV = 5'd16;

   // Digit-serial multiplier: one byte of the operand per cycle
   localparam int unsigned DigitW      = 8;
   localparam int unsigned DigitCount  = BlockW / DigitW;
   localparam int unsigned DigitCntW   = $clog2(DigitCount);

   // Reflected reduction polynomial, 0xE1 in the top byte
   localparam logic [BlockW-1:0] RedPoly = {8'hE1, 120'd0};

   // Register file
   localparam int unsigned CsrIndexW = 4;
   localparam logic [CsrIndexW-1:0] CSR_KEY_HI  = 4'd0;
   localparam logic [CsrIndexW-1:0] CSR_KEY_LO  = 4'd1;
   localparam logic [CsrIndexW-1:0] CSR_MASK_HI = 4'd2;
   localparam logic [CsrIndexW-1:0] CSR_MASK_LO = 4'd3;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_LEN,
      ST_EMIT
   } state_type;

   // Multiplier status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

// ----- hw/rtl/ghash_digit_mul.sv -----
// ----------------------------------------------------------------------------
// ghash_digit_mul
// Digit-serial GF(2^128) multiplier. The operand shifts out one byte per
// cycle, most significant bit first; each cycle performs eight conditional
// accumulate and reduce steps.
// ----------------------------------------------------------------------------
module ghash_digit_mul
   import ghash_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [BlockW-1:0] operand,
   input  logic [BlockW-1:0] key,
   output mul_stat_type      stat,
   output logic [BlockW-1:0] product
);

   logic [BlockW-1:0]    x_ff, x_in;
   logic [BlockW-1:0]    v_ff, v_in;
   logic [BlockW-1:0]    z_ff, z_in;
   logic [DigitCntW-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic [BlockW-1:0]    z_step, v_step;
   logic                 last_digit;

   // Process one digit: eight accumulate and reduce steps
   always_comb begin
      logic [BlockW-1:0] z;
      logic [BlockW-1:0] v;
      logic              carry;
      z = z_ff;
      v = v_ff;
      for (int k = 0; k < DigitW; k++) begin
         if (x_ff[BlockW-1-k]) begin
            z = z ^ v;
         end
         carry = v[0];
         v     = v >> 1;
         if (carry) begin
            v = v ^ RedPoly;
         end
      end
      z_step = z;
      v_step = v;
   end

   assign last_digit = (cnt_ff == DigitCntW'(DigitCount - 1));

   // Load on start, advance one digit per cycle while running
   always_comb begin
      x_in   = x_ff;
      v_in   = v_ff;
      z_in   = z_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         x_in   = operand;
         v_in   = key;
         z_in   = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         x_in   = x_ff << DigitW;
         v_in   = v_step;
         z_in   = z_step;
         cnt_in = cnt_ff + 1'b1;
         if (last_digit) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      v_ff <= v_in;
      z_ff <= z_in;
   end

   // Product is ready in the cycle of the last digit
   assign stat.busy = run_ff;
   assign stat.done = run_ff && last_digit;
   assign product   = z_step;

endmodule

// ----- hw/rtl/ghash_tag_engine_unit.sv -----
// ----------------------------------------------------------------------------
// ghash_tag_engine_unit
// GCM GHASH tag engine. The req channel carries 16-byte blocks tagged AAD or
// ciphertext with a count of valid leading bytes, plus a finish flag; the rsp
// channel carries the 128-bit tag. H and E(K,Y0) are written over csr, and
// the user must do so only while the engine is idle, unchecked by the block.
// A block with data is accepted in idle and then runs through the byte-serial
// GF(2^128) multiplier. A finishing block adds a pass for the length block
// and a step that loads the tag into the output register; an empty block
// without finish is absorbed in idle. The multiplier sets the rate:
// one item is in flight at a time and req_stall stays high while it runs.
// The tag register holds while rsp_stall is high; the next block is still
// accepted, and a later finish waits only if the tag is still untaken.
// Reset clears the accumulator, byte counters, registers and rsp_valid.
// ----------------------------------------------------------------------------
module ghash_tag_engine_unit
   import ghash_pkg::*;
#(
   parameter int unsigned COUNT_BITS = 32
)(
   input  logic                 clock,
   input  logic                 reset,
   // input blocks
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_block_kind,
   input  logic [4:0]           req_valid_bytes,
   input  logic [HalfW-1:0]     req_block_hi,
   input  logic [HalfW-1:0]     req_block_lo,
   input  logic                 req_finish,
   // tag output
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [HalfW-1:0]     rsp_tag_hi,
   output logic [HalfW-1:0]     rsp_tag_lo,
   // register writes
   input  logic                 csr_write,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [HalfW-1:0]     csr_wdata
);

   state_type              state_ff, state_in;
   logic [BlockW-1:0]      acc_ff, acc_in;
   logic [COUNT_BITS-1:0]  aad_cnt_ff, aad_cnt_in;
   logic [COUNT_BITS-1:0]  text_cnt_ff, text_cnt_in;
   logic                   fin_ff, fin_in;
   logic [HalfW-1:0]       key_hi_ff, key_lo_ff, mask_hi_ff, mask_lo_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BlockW-1:0]      rsp_tag_ff, rsp_tag_in;

   logic                   mul_start;
   logic [BlockW-1:0]      mul_operand;
   logic [BlockW-1:0]      mul_product;
   mul_stat_type           mul_stat;

   logic                   req_transfer;
   logic                   out_free;
   logic [4:0]             vb_clip;
   logic [BlockW-1:0]      byte_mask;
   logic [BlockW-1:0]      len_block;
   logic [COUNT_BITS:0]    add_sum;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff  <= '0;
         key_lo_ff  <= '0;
         mask_hi_ff <= '0;
         mask_lo_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KEY_HI:  key_hi_ff  <= csr_wdata;
            CSR_KEY_LO:  key_lo_ff  <= csr_wdata;
            CSR_MASK_HI: mask_hi_ff <= csr_wdata;
            CSR_MASK_LO: mask_lo_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clip the byte count and build the byte keep mask
   assign vb_clip = (req_valid_bytes > BlockBytesV) ? BlockBytesV : req_valid_bytes;

   always_comb begin
      byte_mask = '0;
      for (int j = 0; j < BlockBytes; j++) begin
         byte_mask[BlockW-1-ByteW*j -: ByteW] = (vb_clip > 5'(j)) ? 8'hFF : 8'h00;
      end
   end

   // Length block: bit counts, one 64-bit half each
   assign len_block = {HalfW'({aad_cnt_ff, 3'b000}), HalfW'({text_cnt_ff, 3'b000})};

   // Saturating byte count for the accepted block
   assign add_sum = {1'b0, (req_block_kind ? text_cnt_ff : aad_cnt_ff)}
                    + (COUNT_BITS+1)'(vb_clip);

   assign req_transfer = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      aad_cnt_in   = aad_cnt_ff;
      text_cnt_in  = text_cnt_ff;
      fin_in       = fin_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_start    = 1'b0;
      mul_operand  = acc_ff ^ len_block;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               fin_in = req_finish;
               if (vb_clip != 5'd0) begin
                  mul_start   = 1'b1;
                  mul_operand = acc_ff ^ ({req_block_hi, req_block_lo} & byte_mask);
                  state_in    = ST_HASH;
                  if (req_block_kind) begin
                     text_cnt_in = add_sum[COUNT_BITS] ? '1 : add_sum[COUNT_BITS-1:0];
                  end else begin
                     aad_cnt_in = add_sum[COUNT_BITS] ? '1 : add_sum[COUNT_BITS-1:0];
                  end
               end else if (req_finish) begin
                  mul_start = 1'b1;
                  state_in  = ST_LEN;
               end
            end
         end
         ST_HASH: begin
            if (mul_stat.done) begin
               if (fin_ff) begin
                  mul_start   = 1'b1;
                  mul_operand = mul_product ^ len_block;
                  state_in    = ST_LEN;
               end else begin
                  acc_in   = mul_product;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LEN: begin
            if (mul_stat.done) begin
               acc_in   = mul_product;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // load the tag once the output register is free, then clear
            if (out_free) begin
               rsp_tag_in   = acc_ff ^ {mask_hi_ff, mask_lo_ff};
               rsp_valid_in = 1'b1;
               acc_in       = '0;
               aad_cnt_in   = '0;
               text_cnt_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         aad_cnt_ff   <= '0;
         text_cnt_ff  <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         aad_cnt_ff   <= aad_cnt_in;
         text_cnt_ff  <= text_cnt_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tag_ff <= rsp_tag_in;
   end

   ghash_digit_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (mul_operand),
      .key     ({key_hi_ff, key_lo_ff}),
      .stat    (mul_stat),
      .product (mul_product)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_tag_hi = rsp_tag_ff[BlockW-1:HalfW];
   assign rsp_tag_lo = rsp_tag_ff[HalfW-1:0];

`ifndef SYNTHESIS
   // multiplier only runs for a block or the length fold
   a_mul_owned: assert property (@(posedge clock) disable iff (reset)
      mul_stat.busy |-> (state_ff == ST_HASH || state_ff == ST_LEN))
      else $error("multiplier busy outside a hash state");

   // idle engine never has a product pending
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mul_stat.busy)
      else $error("multiplier busy while idle");

   // a free output register takes the tag and the state is cleared
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !rsp_valid_ff) |=>
         (rsp_valid_ff && acc_ff == '0 && aad_cnt_ff == '0 && text_cnt_ff == '0))
      else $error("tag not emitted or state not cleared");

   // an empty block without finish leaves the accumulator alone
   a_empty_block: assert property (@(posedge clock) disable iff (reset)
      (req_transfer && req_valid_bytes == 5'd0 && !req_finish) |=>
         (state_ff == ST_IDLE && $stable(acc_ff)))
      else $error("empty block disturbed the accumulator");
`endif

endmodule
